// ----- hw/rtl/tist_pkg.sv -----
// Shared types and constants for the touch identifier slot table.
// Used by tist_ctrl and touch_id_slot_table; depends on nothing.
package tist_pkg;

    localparam logic [31:0] IDENT_FREE = 32'hFFFF_FFFF;
    localparam int          POS_W      = 64;
    localparam int          SLOT_OUT_W = 4;

    typedef enum logic [2:0] {
        CMD_ACQUIRE     = 3'd0,
        CMD_FIND        = 3'd1,
        CMD_RELEASE     = 3'd2,
        CMD_RELEASE_ALL = 3'd3,
        CMD_OWNS        = 3'd4,
        CMD_SET_POS     = 3'd5,
        CMD_GET_POS     = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [31:0]       ident;
        logic [7:0]        slot_index;
        logic [POS_W-1:0]  new_x;
        logic [POS_W-1:0]  new_y;
    } req_t;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_OUT_W-1:0] slot;
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_y;
    } res_t;

endpackage

// ----- hw/rtl/tist_pos_ram.sv -----
// Position memory: one x/y pair per slot, one write and one registered read port.
// Stand-alone; no package needed.
module tist_pos_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 128
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/tist_ctrl.sv -----
// Command sequencer: identifier memory, occupancy flags, scan engine and
// position memory control. Depends on tist_pkg and tist_pos_ram.
module tist_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  tist_pkg::req_t in_req,
    output logic          res_valid,
    input  logic          res_ready,
    output tist_pkg::res_t res
);
    import tist_pkg::*;

    localparam int AW = $clog2(SLOTS > 1 ? SLOTS : 2);
    localparam int CW = $clog2(SLOTS + 1);

    state_t          state_reg, state_next;
    req_t            req_reg;
    logic [CW-1:0]   cnt_reg;
    logic            cmp_vld_reg;
    logic [AW-1:0]   cmp_addr_reg;
    logic            found_vld_reg;
    logic [AW-1:0]   found_addr_reg;
    logic            free_vld_reg;
    logic [AW-1:0]   free_addr_reg;
    logic [SLOTS-1:0] occ_reg;
    logic [31:0]     id_rd_reg;
    logic [31:0]     id_mem [SLOTS];

    logic            scan_rd, id_wr, occ_set, occ_clr, occ_clr_all;
    logic            pos_rd, pos_wr;
    logic [AW-1:0]   pos_wr_addr;
    logic [2*POS_W-1:0] pos_wr_data, pos_rd_data;
    logic            in_range, slot_occ, ident_is_free;
    logic [AW-1:0]   sidx;
    logic            hit, free_hit;
    logic [7:0]      found_wide, free_wide;

    assign in_range      = {1'b0, req_reg.slot_index} < 9'(SLOTS);
    assign sidx          = req_reg.slot_index[AW-1:0];
    assign slot_occ      = in_range && occ_reg[sidx];
    assign ident_is_free = req_reg.ident == IDENT_FREE;
    assign found_wide    = 8'(found_addr_reg);
    assign free_wide     = 8'(free_addr_reg);

    // first matching and first free entry seen by the compare stage
    assign hit      = cmp_vld_reg && occ_reg[cmp_addr_reg] && !found_vld_reg &&
                      (id_rd_reg == req_reg.ident);
    assign free_hit = cmp_vld_reg && !occ_reg[cmp_addr_reg] && !free_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        scan_rd     = 1'b0;
        id_wr       = 1'b0;
        occ_set     = 1'b0;
        occ_clr     = 1'b0;
        occ_clr_all = 1'b0;
        pos_rd      = 1'b0;
        pos_wr      = 1'b0;
        pos_wr_addr = sidx;
        pos_wr_data = '0;
        res_valid   = 1'b0;
        res         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (req_reg.cmd)
                    CMD_ACQUIRE, CMD_FIND, CMD_RELEASE: begin
                        state_next = ident_is_free ? ST_FINISH : ST_SCAN;
                    end
                    CMD_GET_POS: begin
                        pos_rd     = slot_occ;
                        state_next = ST_FINISH;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN: begin
                if (cnt_reg == CW'(SLOTS)) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_rd = 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (res_ready) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    case (req_reg.cmd)
                        CMD_ACQUIRE: begin
                            if (!ident_is_free && found_vld_reg) begin
                                res.ok   = 1'b1;
                                res.slot = found_wide[SLOT_OUT_W-1:0];
                            end else if (!ident_is_free && free_vld_reg) begin
                                // claim the lowest free slot and zero its position
                                res.ok      = 1'b1;
                                res.slot    = free_wide[SLOT_OUT_W-1:0];
                                id_wr       = 1'b1;
                                occ_set     = 1'b1;
                                pos_wr      = 1'b1;
                                pos_wr_addr = free_addr_reg;
                            end
                        end
                        CMD_FIND: begin
                            if (found_vld_reg) begin
                                res.ok   = 1'b1;
                                res.slot = found_wide[SLOT_OUT_W-1:0];
                            end
                        end
                        CMD_RELEASE: begin
                            occ_clr = found_vld_reg;
                        end
                        CMD_RELEASE_ALL: begin
                            occ_clr_all = 1'b1;
                        end
                        CMD_OWNS: begin
                            res.ok = slot_occ;
                        end
                        CMD_SET_POS: begin
                            pos_wr      = in_range;
                            pos_wr_data = {req_reg.new_y, req_reg.new_x};
                        end
                        CMD_GET_POS: begin
                            if (slot_occ) begin
                                res.ok    = 1'b1;
                                res.pos_x = pos_rd_data[POS_W-1:0];
                                res.pos_y = pos_rd_data[2*POS_W-1:POS_W];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // scan bookkeeping and occupancy flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_addr_reg   <= '0;
            found_vld_reg  <= 1'b0;
            found_addr_reg <= '0;
            free_vld_reg   <= 1'b0;
            free_addr_reg  <= '0;
            occ_reg        <= '0;
        end else begin
            cmp_vld_reg <= scan_rd;
            if (scan_rd) begin
                cmp_addr_reg <= cnt_reg[AW-1:0];
                cnt_reg      <= cnt_reg + CW'(1);
            end
            if (state_reg == ST_EXEC) begin
                cnt_reg       <= '0;
                found_vld_reg <= 1'b0;
                free_vld_reg  <= 1'b0;
            end else begin
                if (hit) begin
                    found_vld_reg  <= 1'b1;
                    found_addr_reg <= cmp_addr_reg;
                end
                if (free_hit) begin
                    free_vld_reg  <= 1'b1;
                    free_addr_reg <= cmp_addr_reg;
                end
            end
            if (occ_clr_all) begin
                occ_reg <= '0;
            end else if (occ_set) begin
                occ_reg[free_addr_reg] <= 1'b1;
            end else if (occ_clr) begin
                occ_reg[found_addr_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            req_reg <= in_req;
        end
        if (scan_rd) begin
            id_rd_reg <= id_mem[cnt_reg[AW-1:0]];
        end
        if (id_wr) begin
            id_mem[free_addr_reg] <= req_reg.ident;
        end
    end

    tist_pos_ram #(
        .DEPTH (SLOTS),
        .WIDTH (2 * POS_W)
    ) u_pos_ram (
        .aclk    (aclk),
        .wr_en   (pos_wr),
        .wr_addr (pos_wr_addr),
        .wr_data (pos_wr_data),
        .rd_en   (pos_rd),
        .rd_addr (sidx),
        .rd_data (pos_rd_data)
    );

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(SLOTS))
        else $error("scan counter past table depth");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after result");

    a_found_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && found_vld_reg) |-> occ_reg[found_addr_reg])
        else $error("matched slot is not occupied");

    a_free_unoccupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && free_vld_reg) |-> !occ_reg[free_addr_reg])
        else $error("free candidate slot is occupied");

endmodule

// ----- hw/rtl/touch_id_slot_table.sv -----
// Top level of the touch identifier slot table: stream ports, request
// unpacking and result register. Depends on tist_pkg and tist_ctrl.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | ident, slot_index, new_x, new_y         | command
//  m_      | out | slot_out, pos_x, pos_y                  | ok
//
// Acquire, find and release with a real identifier scan the identifier memory
// one entry per cycle between acceptance and m_tvalid, followed by its compare
// and drain stages; all other requests go from execute straight to finish.
// One request is in work at a time; the next is accepted while a finished
// result still waits in the output register.
// aresetn clears the state machine and marks every slot free.
// A stalled m_tready holds the result and, if still held, the next finish.
module touch_id_slot_table #(
    parameter int SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] ident, [39:32] slot_index, [103:40] new_x, [167:104] new_y
    input  logic [167:0] s_tdata,
    // [2:0] command
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] slot_out, [67:4] pos_x, [131:68] pos_y, [135:132] zero
    output logic [135:0] m_tdata,
    // [0] ok
    output logic [0:0]   m_tuser
);
    import tist_pkg::*;

    req_t in_req;
    res_t res, res_reg;
    logic res_valid, res_ready;
    logic m_tvalid_reg;

    assign in_req.cmd        = cmd_t'(s_tuser);
    assign in_req.ident      = s_tdata[31:0];
    assign in_req.slot_index = s_tdata[39:32];
    assign in_req.new_x      = s_tdata[103:40];
    assign in_req.new_y      = s_tdata[167:104];

    // take a new result when the register is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    tist_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, res_reg.pos_y, res_reg.pos_x, res_reg.slot};
    assign m_tuser  = res_reg.ok;

endmodule
